>>> design/vogi_pkg.sv
// ----------------------------------------------------------------------------
// vogi_pkg: shared types and codes for the voxel occupancy grid
// Holds the item, result, command and register types and the opcode and
// register index codes that the front, queue, back and top level share.
// ----------------------------------------------------------------------------
package vogi_pkg;

   // Operation codes of an input item.
   localparam logic [2:0] OP_CLEAR     = 3'd0;
   localparam logic [2:0] OP_MARK_OCC  = 3'd1;
   localparam logic [2:0] OP_MARK_FREE = 3'd2;
   localparam logic [2:0] OP_INFLATE   = 3'd3;
   localparam logic [2:0] OP_QUERY     = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] REG_SIZE_X   = 3'd0;
   localparam logic [2:0] REG_SIZE_Y   = 3'd1;
   localparam logic [2:0] REG_SIZE_Z   = 3'd2;
   localparam logic [2:0] REG_ORIGIN_X = 3'd3;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd5;
   localparam logic [2:0] REG_RECIP    = 3'd6;

   // Voxel indexes are carried at a fixed width of IDX_W bits.
   localparam int IDX_W = 8;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [2:0]         radius;
   } req_type;

   typedef struct packed {
      logic occupied;
      logic in_bounds;
   } rsp_type;

   typedef struct packed {
      logic [5:0]         size_x;
      logic [5:0]         size_y;
      logic [5:0]         size_z;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic [31:0]        recip;
   } cfg_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      logic [2:0]       op;
      logic             ok;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] y;
      logic [IDX_W-1:0] z;
      logic [2:0]       radius;
   } cmd_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MAP,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_CLR,
      B_IDLE,
      B_EXEC,
      B_MWR,
      B_QOUT,
      B_COPY,
      B_SRD,
      B_SCHK,
      B_CMB,
      B_CWR
   } back_state_type;

endpackage

>>> design/vogi_front.sv
// ----------------------------------------------------------------------------
// vogi_front: item intake and position mapping
// Accepts items, maps world positions to voxel indexes one axis at a time
// through a shared multiplier and pushes classified commands to the queue.
// ----------------------------------------------------------------------------
module vogi_front
   import vogi_pkg::*;
#(
   parameter int MAX_X = 32,
   parameter int MAX_Y = 32,
   parameter int MAX_Z = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   input  cfg_type cfg,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   front_state_type    state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   req_type            req_ff, req_in;
   logic [63:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic               ok_ff, ok_in;
   logic [IDX_W-1:0]   ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;

   logic signed [31:0] mul_pos, mul_org;
   logic [32:0]        diff;
   logic [8:0]         ev_size;
   logic               ev_out;

   function automatic logic [8:0] eff_size(logic [5:0] s, int mx);
      eff_size = (32'(s) > mx) ? 9'(mx) : 9'(s);
   endfunction

   // Operand select for the multiplier and bound select for the check.
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_pos = req_ff.pos_x;
            mul_org = cfg.origin_x;
         end
         2'd1: begin
            mul_pos = req_ff.pos_y;
            mul_org = cfg.origin_y;
         end
         default: begin
            mul_pos = req_ff.pos_z;
            mul_org = cfg.origin_z;
         end
      endcase
      case (step_ff)
         2'd1:    ev_size = eff_size(cfg.size_x, MAX_X);
         2'd2:    ev_size = eff_size(cfg.size_y, MAX_Y);
         default: ev_size = eff_size(cfg.size_z, MAX_Z);
      endcase
      diff   = {mul_pos[31], mul_pos} - {mul_org[31], mul_org};
      ev_out = (neg_ff && (cfg.recip != 32'd0)) || (prod_ff[63:32] >= 32'(ev_size));
   end

   // Next state and outputs.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      req_in   = req_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      ok_in    = ok_ff;
      ix_in    = ix_ff;
      iy_in    = iy_ff;
      iz_in    = iz_ff;
      q_push   = 1'b0;
      busy     = (state_ff != F_IDLE);
      q_cmd.op     = req_ff.opcode;
      q_cmd.ok     = ok_ff;
      q_cmd.x      = ix_ff;
      q_cmd.y      = iy_ff;
      q_cmd.z      = iz_ff;
      q_cmd.radius = req_ff.radius;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               req_in  = req_item;
               ok_in   = 1'b1;
               step_in = 2'd0;
               case (req_item.opcode)
                  OP_MARK_OCC, OP_MARK_FREE, OP_QUERY: state_in = F_MAP;
                  OP_CLEAR, OP_INFLATE:                state_in = F_PUSH;
                  default:                             state_in = F_IDLE;
               endcase
            end
         end
         F_MAP: begin
            // Multiply the current axis while checking the previous one.
            prod_in = 64'(diff[31:0]) * 64'(cfg.recip);
            neg_in  = diff[32];
            if (step_ff != 2'd0) begin
               if (ev_out) begin
                  ok_in = 1'b0;
               end
               case (step_ff)
                  2'd1:    ix_in = prod_ff[32 +: IDX_W];
                  2'd2:    iy_in = prod_ff[32 +: IDX_W];
                  default: iz_in = prod_ff[32 +: IDX_W];
               endcase
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      ok_ff   <= ok_in;
      ix_ff   <= ix_in;
      iy_ff   <= iy_in;
      iz_ff   <= iz_in;
   end

endmodule

>>> design/vogi_queue.sv
// ----------------------------------------------------------------------------
// vogi_queue: two-entry command queue
// Decouples the front from the back so that either side can stall alone.
// ----------------------------------------------------------------------------
module vogi_queue
   import vogi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type    entry_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      full     = (count_ff == 2'd2);
      empty    = (count_ff == 2'd0);
      head     = entry_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

>>> design/vogi_back.sv
// ----------------------------------------------------------------------------
// vogi_back: grid store and command execution
// Holds the grid and the inflate snapshot as row-wide memories and carries
// out clear, mark, inflate and query commands taken from the queue.
// ----------------------------------------------------------------------------
module vogi_back
   import vogi_pkg::*;
#(
   parameter int MAX_X      = 32,
   parameter int MAX_Y      = 32,
   parameter int MAX_Z      = 32,
   parameter int MAX_RADIUS = 7
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_empty,
   input  cmd_type q_head,
   output logic    q_pop,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int ROWS = MAX_Y * MAX_Z;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int XW   = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int RDW  = $clog2(MAX_RADIUS + 1);
   localparam int DW   = RDW + 1;
   localparam int CW   = IDX_W + 3;
   localparam int SW   = 12;

   back_state_type     state_ff, state_in;
   logic [RW:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]   y_ff, y_in, z_ff, z_in;
   logic signed [DW-1:0] dy_ff, dy_in, dz_ff, dz_in;
   logic [MAX_X-1:0]   src_ff, src_in;
   cmd_type            cmd_ff, cmd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [MAX_X-1:0]   cell_mem [ROWS];
   logic [MAX_X-1:0]   snap_mem [ROWS];
   logic [MAX_X-1:0]   cell_rd_ff, snap_rd_ff;
   logic [RW-1:0]      cell_raddr, cell_waddr, snap_raddr, snap_waddr;
   logic               cell_we, snap_we;
   logic [MAX_X-1:0]   cell_wdata, snap_wdata;

   logic [8:0]         sx_eff, sy_eff, sz_eff;
   logic [RDW-1:0]     r_eff;
   logic signed [DW-1:0] r_pos;
   logic [MAX_X-1:0]   xmask, dil, src_now;
   logic signed [CW-1:0] ty, tz;
   logic signed [SW-1:0] dyw, dzw, dd, rr;
   logic [RDW-1:0]     reach;
   logic               cmb_ok, go_next, go_adv;

   function automatic logic [8:0] eff_size(logic [5:0] s, int mx);
      eff_size = (32'(s) > mx) ? 9'(mx) : 9'(s);
   endfunction

   function automatic logic [RW-1:0] row_of(logic [IDX_W-1:0] yy, logic [IDX_W-1:0] zz);
      row_of = RW'(32'(yy) + 32'(MAX_Y) * 32'(zz));
   endfunction

   // Sizes in use, radius and the per-offset geometry of the inflate walk.
   always_comb begin
      sx_eff = eff_size(cfg.size_x, MAX_X);
      sy_eff = eff_size(cfg.size_y, MAX_Y);
      sz_eff = eff_size(cfg.size_z, MAX_Z);
      r_eff  = (32'(cmd_ff.radius) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(cmd_ff.radius);
      r_pos  = $signed({1'b0, r_eff});
      for (int i = 0; i < MAX_X; i++) begin
         xmask[i] = (32'(i) < 32'(sx_eff));
      end
      ty  = $signed({3'b000, y_ff}) + CW'(dy_ff);
      tz  = $signed({3'b000, z_ff}) + CW'(dz_ff);
      dyw = SW'(dy_ff);
      dzw = SW'(dz_ff);
      dd  = dyw * dyw + dzw * dzw;
      rr  = SW'(r_pos) * SW'(r_pos);
      cmb_ok = !ty[CW-1] && (ty < $signed({2'b00, sy_eff}))
            && !tz[CW-1] && (tz < $signed({2'b00, sz_eff})) && (dd <= rr);
      // Half-width of the row span at this offset.
      reach = '0;
      for (int k = 1; k <= MAX_RADIUS; k++) begin
         if (SW'(k * k) + dd <= rr) begin
            reach = reach + RDW'(1);
         end
      end
      // Row dilation of the held source row.
      dil = '0;
      for (int k = 0; k <= MAX_RADIUS; k++) begin
         if (32'(k) <= 32'(reach)) begin
            dil = dil | (src_ff << k) | (src_ff >> k);
         end
      end
      dil     = dil & xmask;
      src_now = snap_rd_ff & xmask;
   end

   // Next state and memory port control.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      src_in       = src_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      cell_raddr   = row_of(cmd_ff.y, cmd_ff.z);
      cell_we      = 1'b0;
      cell_waddr   = row_of(cmd_ff.y, cmd_ff.z);
      cell_wdata   = cell_rd_ff;
      snap_raddr   = row_of(y_ff, z_ff);
      snap_we      = 1'b0;
      snap_waddr   = RW'(cnt_ff - (RW+1)'(1));
      snap_wdata   = cell_rd_ff;
      go_next      = 1'b0;
      go_adv       = 1'b0;
      case (state_ff)
         B_CLR: begin
            // Zero one row per cycle, after reset and for a clear command.
            cell_we    = 1'b1;
            cell_waddr = cnt_ff[RW-1:0];
            cell_wdata = '0;
            cnt_in     = cnt_ff + (RW+1)'(1);
            if (cnt_ff == (RW+1)'(ROWS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            case (cmd_ff.op)
               OP_CLEAR: begin
                  cnt_in   = '0;
                  state_in = B_CLR;
               end
               OP_MARK_OCC, OP_MARK_FREE: begin
                  state_in = cmd_ff.ok ? B_MWR : B_IDLE;
               end
               OP_QUERY: begin
                  if (cmd_ff.ok) begin
                     state_in = B_QOUT;
                  end else begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.occupied    = 1'b1;
                     rsp_in.in_bounds   = 1'b0;
                     state_in           = B_IDLE;
                  end
               end
               OP_INFLATE: begin
                  cnt_in   = '0;
                  state_in = (r_eff == '0) ? B_IDLE : B_COPY;
               end
               default: state_in = B_IDLE;
            endcase
         end
         B_MWR: begin
            cell_we = 1'b1;
            cell_wdata[cmd_ff.x[XW-1:0]] = (cmd_ff.op == OP_MARK_OCC);
            state_in = B_IDLE;
         end
         B_QOUT: begin
            rsp_valid_in     = 1'b1;
            rsp_in.occupied  = cell_rd_ff[cmd_ff.x[XW-1:0]];
            rsp_in.in_bounds = 1'b1;
            state_in         = B_IDLE;
         end
         B_COPY: begin
            // Read row cnt while writing row cnt-1, read in the previous cycle.
            cell_raddr = cnt_ff[RW-1:0];
            snap_we    = (cnt_ff != '0);
            cnt_in     = cnt_ff + (RW+1)'(1);
            if (cnt_ff == (RW+1)'(ROWS)) begin
               snap_we = 1'b1;
               y_in    = '0;
               z_in    = '0;
               if (sx_eff == '0 || sy_eff == '0 || sz_eff == '0) begin
                  state_in = B_IDLE;
               end else begin
                  state_in = B_SRD;
               end
            end
         end
         B_SRD: begin
            state_in = B_SCHK;
         end
         B_SCHK: begin
            if (src_now == '0) begin
               go_next = 1'b1;
            end else begin
               src_in   = src_now;
               dy_in    = -r_pos;
               dz_in    = -r_pos;
               state_in = B_CMB;
            end
         end
         B_CMB: begin
            cell_raddr = row_of(ty[IDX_W-1:0], tz[IDX_W-1:0]);
            if (cmb_ok) begin
               state_in = B_CWR;
            end else begin
               go_adv = 1'b1;
            end
         end
         B_CWR: begin
            cell_we    = 1'b1;
            cell_waddr = row_of(ty[IDX_W-1:0], tz[IDX_W-1:0]);
            cell_wdata = cell_rd_ff | dil;
            go_adv     = 1'b1;
         end
         default: state_in = B_IDLE;
      endcase

      // Step to the next offset (dy,dz) of the square around the source row.
      if (go_adv) begin
         state_in = B_CMB;
         if (dy_ff < r_pos) begin
            dy_in = dy_ff + DW'(1);
         end else begin
            dy_in = -r_pos;
            if (dz_ff < r_pos) begin
               dz_in = dz_ff + DW'(1);
            end else begin
               go_next = 1'b1;
            end
         end
      end

      // Step to the next source row of the snapshot.
      if (go_next) begin
         state_in = B_SRD;
         if (32'(y_ff) + 32'd1 < 32'(sy_eff)) begin
            y_in = y_ff + IDX_W'(1);
         end else begin
            y_in = '0;
            if (32'(z_ff) + 32'd1 < 32'(sz_eff)) begin
               z_in = z_ff + IDX_W'(1);
            end else begin
               state_in = B_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff   <= y_in;
      z_ff   <= z_in;
      dy_ff  <= dy_in;
      dz_ff  <= dz_in;
      src_ff <= src_in;
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   // Grid memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   // Snapshot memory used by inflate.
   always_ff @(posedge clock) begin
      if (snap_we) begin
         snap_mem[snap_waddr] <= snap_wdata;
      end
      snap_rd_ff <= snap_mem[snap_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> design/voxel_occupancy_grid_inflate.sv
// ----------------------------------------------------------------------------
// voxel_occupancy_grid_inflate: 3D one-bit occupancy grid with inflation
// Top level: configuration registers, intake front, command queue and the
// grid back end.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each query item yields
// one result, shown for one cycle with rsp_valid; the receiver cannot stall
// it. A mark or query item occupies the front while one shared multiplier
// maps the three axes in turn, and then the back after it leaves the queue; a
// two-entry queue sits between them. A clear zeroes all MAX_Y*MAX_Z grid rows,
// one grid row per cycle. An inflate copies the grid to its snapshot, then
// reads each source row in use and, for each row holding an occupied cell,
// visits every offset pair (dy,dz) of the (2r+1)^2 square, writing the dilated
// row where the offset lies inside the sphere and the grid. After reset a
// clearing pass over all MAX_Y*MAX_Z rows runs; items entered meanwhile wait
// in the queue and the front. The user must write configuration only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module voxel_occupancy_grid_inflate
   import vogi_pkg::*;
#(
   parameter int MAX_X      = 32,
   parameter int MAX_Y      = 32,
   parameter int MAX_Z      = 32,
   parameter int MAX_RADIUS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full, q_push, q_empty, q_pop;
   cmd_type q_cmd, q_head;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SIZE_X:   cfg_in.size_x   = csr_wdata[5:0];
            REG_SIZE_Y:   cfg_in.size_y   = csr_wdata[5:0];
            REG_SIZE_Z:   cfg_in.size_z   = csr_wdata[5:0];
            REG_ORIGIN_X: cfg_in.origin_x = $signed(csr_wdata);
            REG_ORIGIN_Y: cfg_in.origin_y = $signed(csr_wdata);
            REG_ORIGIN_Z: cfg_in.origin_z = $signed(csr_wdata);
            REG_RECIP:    cfg_in.recip    = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x   <= 6'd32;
         cfg_ff.size_y   <= 6'd32;
         cfg_ff.size_z   <= 6'd32;
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
         cfg_ff.recip    <= 32'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vogi_front #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y),
      .MAX_Z (MAX_Z)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   vogi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   vogi_back #(
      .MAX_X      (MAX_X),
      .MAX_Y      (MAX_Y),
      .MAX_Z      (MAX_Z),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for voxel_occupancy_grid_inflate
// Drives a short table of directed items and then several phases of random
// items under different grid settings. A behavioral copy of the grid predicts
// every query answer; answers are compared in order with it or typed answers.
// ----------------------------------------------------------------------------
module tb_top;
   import vogi_pkg::*;

   localparam int GRID_X = 32;
   localparam int GRID_Y = 32;
   localparam int GRID_Z = 32;
   localparam int GRID_CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int RADIUS_CAP = 7;
   localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
   localparam int CYCLE_LIMIT = 30_000_000;
   localparam int REPORT_LIMIT = 10;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   voxel_occupancy_grid_inflate dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the grid, its snapshot and the register settings.
   bit      occ_grid [GRID_CELLS];
   bit      occ_snapshot [GRID_CELLS];
   cfg_type grid_cfg;

   rsp_type pending_answers [$];
   int      mismatches;
   int      answers_seen;
   int      cycle_count;
   int      n_query, n_mark, n_inflate, n_clear, n_spare;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Compare each answer with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         answers_seen <= answers_seen + 1;
         if (pending_answers.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < REPORT_LIMIT)
               $display("Unexpected answer occ=%0b inb=%0b", rsp_item.occupied,
                        rsp_item.in_bounds);
         end else begin
            rsp_type want;
            want = pending_answers.pop_front();
            if (want.occupied !== rsp_item.occupied
                || want.in_bounds !== rsp_item.in_bounds) begin
               mismatches <= mismatches + 1;
               if (mismatches < REPORT_LIMIT)
                  $display("Answer mismatch: expected occ=%0b inb=%0b, got occ=%0b inb=%0b",
                           want.occupied, want.in_bounds, rsp_item.occupied,
                           rsp_item.in_bounds);
            end
         end
      end
   end

   function automatic int eff_size(logic [5:0] sz, int cap);
      return (sz > cap) ? cap : int'(sz);
   endfunction

   // Map one axis of a world position to a voxel index.
   function automatic bit axis_to_index(logic signed [31:0] pos, logic signed [31:0] org,
                                        int sz, output int idx);
      longint      diff;
      logic [63:0] prod;
      logic [31:0] voxel;
      diff = longint'(pos) - longint'(org);
      idx = 0;
      if (diff < 0) begin
         if (grid_cfg.recip != 0)
            return 1'b0;
         diff = 0;
      end
      prod = 64'(diff) * 64'(grid_cfg.recip);
      voxel = prod[63:32];
      if (voxel >= sz)
         return 1'b0;
      idx = int'(voxel);
      return 1'b1;
   endfunction

   function automatic bit pos_to_cell(req_type r, output int addr);
      int x, y, z;
      addr = 0;
      if (!axis_to_index(r.pos_x, grid_cfg.origin_x, eff_size(grid_cfg.size_x, GRID_X), x))
         return 1'b0;
      if (!axis_to_index(r.pos_y, grid_cfg.origin_y, eff_size(grid_cfg.size_y, GRID_Y), y))
         return 1'b0;
      if (!axis_to_index(r.pos_z, grid_cfg.origin_z, eff_size(grid_cfg.size_z, GRID_Z), z))
         return 1'b0;
      addr = x + GRID_X * (y + GRID_Y * z);
      return 1'b1;
   endfunction

   // Grow every occupied cell by a sphere of the given radius.
   function automatic void inflate_grid(int r);
      int sx, sy, sz, rr, x, y, z, dy, dz, ty, tz, reach, lo, hi, t;
      sx = eff_size(grid_cfg.size_x, GRID_X);
      sy = eff_size(grid_cfg.size_y, GRID_Y);
      sz = eff_size(grid_cfg.size_z, GRID_Z);
      if (r > RADIUS_CAP) r = RADIUS_CAP;
      if (r == 0) return;
      rr = r * r;
      occ_snapshot = occ_grid;
      for (z = 0; z < sz; z++)
         for (y = 0; y < sy; y++)
            for (x = 0; x < sx; x++) begin
               if (!occ_snapshot[x + GRID_X * (y + GRID_Y * z)]) continue;
               for (dz = -r; dz <= r; dz++) begin
                  tz = z + dz;
                  if (tz < 0 || tz >= sz) continue;
                  for (dy = -r; dy <= r; dy++) begin
                     ty = y + dy;
                     if (ty < 0 || ty >= sy) continue;
                     if (dy * dy + dz * dz > rr) continue;
                     reach = 0;
                     while ((reach + 1) * (reach + 1) + dy * dy + dz * dz <= rr)
                        reach++;
                     lo = (x - reach < 0) ? 0 : x - reach;
                     hi = (x + reach > sx - 1) ? sx - 1 : x + reach;
                     for (t = lo; t <= hi; t++)
                        occ_grid[t + GRID_X * (ty + GRID_Y * tz)] = 1'b1;
                  end
               end
            end
   endfunction

   // Apply one accepted item to the shadow grid; report the answer it yields.
   function automatic bit predict_item(req_type r, output rsp_type ans);
      int addr;
      bit ok;
      ans = '0;
      case (r.opcode)
         OP_CLEAR: begin
            occ_grid = '{default: 1'b0};
            n_clear++;
         end
         OP_MARK_OCC, OP_MARK_FREE: begin
            if (pos_to_cell(r, addr))
               occ_grid[addr] = (r.opcode == OP_MARK_OCC);
            n_mark++;
         end
         OP_INFLATE: begin
            inflate_grid(int'(r.radius));
            n_inflate++;
         end
         OP_QUERY: begin
            ok = pos_to_cell(r, addr);
            ans.occupied = ok ? occ_grid[addr] : 1'b1;
            ans.in_bounds = ok;
            n_query++;
            return 1'b1;
         end
         default: n_spare++;
      endcase
      return 1'b0;
   endfunction

   // Present an item until it is taken, then record its prediction.
   task automatic send_item(req_type r, bit fixed_ans = 1'b0, rsp_type typed = '0);
      rsp_type ans;
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      if (predict_item(r, ans))
         pending_answers.push_back(fixed_ans ? typed : ans);
   endtask

   // Random gap after an item: mostly none, sometimes short, rarely long.
   task automatic sender_gap();
      int roll, gap;
      roll = $urandom_range(0, 99);
      gap = (roll < 65) ? 0 : (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Fence with a query and wait until every answer has come back.
   task automatic drain();
      req_type r;
      r = '0;
      r.opcode = OP_QUERY;
      send_item(r);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write all seven registers back to back while the block is idle.
   task automatic configure(cfg_type c);
      logic [31:0] vals [7];
      vals = '{32'(c.size_x), 32'(c.size_y), 32'(c.size_z), c.origin_x, c.origin_y,
               c.origin_z, c.recip};
      for (int i = REG_SIZE_X; i <= REG_RECIP; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      grid_cfg = c;
   endtask

   // Random position: anywhere if recip is zero, else mostly inside the grid.
   function automatic logic signed [31:0] pick_pos(logic signed [31:0] org, logic [5:0] sz,
                                                   int cap);
      logic [63:0] span;
      if (grid_cfg.recip == 0 || $urandom_range(0, 99) < 20)
         return $urandom;
      span = (64'(eff_size(sz, cap)) << 32) / grid_cfg.recip;
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      if (span == 0) span = 1;
      return org + 32'($urandom % 32'(span));
   endfunction

   // Directed table.
   typedef struct {
      logic [2:0]  op;
      logic [31:0] px, py, pz;
      logic [2:0]  rad;
      bit          typed;
      rsp_type     ans;
   } vector_row;

   localparam logic [31:0] ONE = 32'h0001_0000;

   vector_row vectors [] = '{
      '{OP_QUERY,     0,         0,         0,         0, 1, 2'b01},
      '{OP_QUERY,     -ONE,      0,         0,         0, 1, 2'b10},
      '{OP_QUERY,     32*ONE,    0,         0,         0, 1, 2'b10},
      '{OP_QUERY,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 2'b10},
      '{OP_QUERY,     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 2'b10},
      '{OP_MARK_OCC,  3*ONE,     4*ONE,     5*ONE+ONE/2, 0, 0, 2'b00},
      '{OP_QUERY,     3*ONE,     4*ONE,     5*ONE,     0, 1, 2'b11},
      '{OP_MARK_FREE, 3*ONE,     4*ONE,     5*ONE,     0, 0, 2'b00},
      '{OP_QUERY,     3*ONE,     4*ONE,     5*ONE,     0, 1, 2'b01},
      '{OP_MARK_OCC,  10*ONE,    10*ONE,    10*ONE,    0, 0, 2'b00},
      '{OP_INFLATE,   0,         0,         0,         0, 0, 2'b00},
      '{OP_QUERY,     11*ONE,    10*ONE,    10*ONE,    0, 1, 2'b01},
      '{OP_INFLATE,   0,         0,         0,         2, 0, 2'b00},
      '{OP_QUERY,     12*ONE,    10*ONE,    10*ONE,    0, 1, 2'b11},
      '{OP_QUERY,     11*ONE,    11*ONE,    10*ONE,    0, 0, 2'b00},
      '{OP_QUERY,     13*ONE,    10*ONE,    10*ONE,    0, 0, 2'b00},
      '{OP_MARK_OCC,  31*ONE,    31*ONE,    31*ONE,    0, 0, 2'b00},
      '{OP_INFLATE,   0,         0,         0,         7, 0, 2'b00},
      '{OP_QUERY,     31*ONE,    25*ONE,    31*ONE,    0, 0, 2'b00},
      '{OP_QUERY,     26*ONE,    27*ONE,    29*ONE,    0, 0, 2'b00},
      '{OP_CLEAR,     0,         0,         0,         0, 0, 2'b00},
      '{OP_QUERY,     10*ONE,    10*ONE,    10*ONE,    0, 1, 2'b01},
      '{OP_FIRST_UNUSED, 0,      0,         0,         7, 0, 2'b00},
      '{OP_LAST_UNUSED,  ONE,    ONE,       ONE,       0, 0, 2'b00},
      '{OP_QUERY,     31*ONE,    31*ONE,    31*ONE,    0, 1, 2'b01}
   };

   // Grid settings for the random phases, extremes among them.
   function automatic cfg_type phase_cfg(int k);
      cfg_type c;
      c = '{size_x: 6'd8, size_y: 6'd8, size_z: 6'd8, origin_x: $urandom,
            origin_y: $urandom, origin_z: $urandom, recip: 32'h0001_0000};
      case (k)
         0: c = '{32, 32, 32, 0, 0, 0, 32'h0001_0000};
         1: c.recip = 32'h0002_8000;
         2: c = '{1, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0001_0000};
         3: c = '{0, 5, 7, 0, 0, 0, 32'h0001_0000};
         4: c = '{63, 63, 63, 0, 0, 0, 32'hFFFF_FFFF};
         5: c.recip = 32'd1;
         6: begin
            c.size_x = 6'd12; c.size_y = 6'd3; c.size_z = 6'd9; c.recip = 32'd0;
         end
         7: begin
            c.size_x = 6'($urandom_range(1, 16)); c.size_y = 6'($urandom_range(1, 16));
            c.size_z = 6'($urandom_range(1, 16)); c.recip = 32'($urandom_range(1, 32'h0004_0000));
         end
         default: c.recip = $urandom;
      endcase
      return c;
   endfunction

   // Stimulus.
   initial begin
      req_type r;
      cfg_type c;
      int      roll, cells;
      cycle_count = 0;
      mismatches = 0;
      answers_seen = 0;
      n_query = 0; n_mark = 0; n_inflate = 0; n_clear = 0; n_spare = 0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_index = REG_SIZE_X;
      csr_wdata = '0;
      occ_grid = '{default: 1'b0};
      grid_cfg = '{32, 32, 32, 0, 0, 0, 32'h0001_0000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, at reset settings.
      foreach (vectors[i]) begin
         r.opcode = vectors[i].op;
         r.pos_x = vectors[i].px;
         r.pos_y = vectors[i].py;
         r.pos_z = vectors[i].pz;
         r.radius = vectors[i].rad;
         send_item(r, vectors[i].typed, vectors[i].ans);
         sender_gap();
      end
      drain();

      // Random phases.
      for (int k = 0; k < 9; k++) begin
         c = phase_cfg(k);
         configure(c);
         cells = eff_size(c.size_x, GRID_X) * eff_size(c.size_y, GRID_Y)
                 * eff_size(c.size_z, GRID_Z);
         for (int n = 0; n < 120; n++) begin
            roll = $urandom_range(0, 999);
            r.pos_x = pick_pos(c.origin_x, c.size_x, GRID_X);
            r.pos_y = pick_pos(c.origin_y, c.size_y, GRID_Y);
            r.pos_z = pick_pos(c.origin_z, c.size_z, GRID_Z);
            r.radius = $urandom;
            if (roll < 30)       r.opcode = OP_CLEAR;
            else if (roll < 360) r.opcode = OP_MARK_OCC;
            else if (roll < 520) r.opcode = OP_MARK_FREE;
            else if (roll < 545) r.opcode = OP_INFLATE;
            else if (roll < 975) r.opcode = OP_QUERY;
            else r.opcode = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            // Keep inflation of large grids cheap.
            if (r.opcode == OP_INFLATE && cells > 1000)
               r.radius = 3'($urandom_range(0, 2));
            send_item(r);
            if (n == 60)
               drain();
            else
               sender_gap();
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("Covered %0d queries, %0d marks, %0d inflates, %0d clears, %0d unused opcodes;",
               n_query, n_mark, n_inflate, n_clear, n_spare);
      $display("%0d answers checked over ten grid settings, %0d mismatches.",
               answers_seen, mismatches);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> voxel_occupancy_grid_inflate.f
design/vogi_pkg.sv
design/vogi_front.sv
design/vogi_queue.sv
design/vogi_back.sv
design/voxel_occupancy_grid_inflate.sv
tb/sv/tb_top.sv
